// ===== rtl/core/bass_beat_detector_assert.svh =====
// ----------------------------------------------------------------------------
// bass beat detector assertion macros
// shared concurrent assertion forms for the checker, clocked on clock
// ----------------------------------------------------------------------------
`ifndef BASS_BEAT_DETECTOR_ASSERT_SVH
`define BASS_BEAT_DETECTOR_ASSERT_SVH

// checked outside reset
`define BBD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define BBD_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ===== rtl/core/bbd_pkg.sv =====
// ----------------------------------------------------------------------------
// bbd_pkg
// types, constants and register codes of the bass beat detector
// ----------------------------------------------------------------------------
package bbd_pkg;

   // sizing
   localparam int unsigned HISTORY_DEPTH = 32;
   localparam int unsigned FRAME_BINS    = 512;
   localparam int unsigned AMP_BITS      = 16;

   localparam int unsigned BIN_W    = 9;
   localparam int unsigned AMP_W    = AMP_BITS;
   localparam int unsigned VOL_W    = 16;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned ACC_W    = 25;
   localparam int unsigned VAR_W    = 31;
   localparam int unsigned HIST_W   = $clog2(HISTORY_DEPTH);
   localparam int unsigned SUM_W    = AMP_W + HIST_W;
   localparam int unsigned SQ_W     = 2 * AMP_W + HIST_W;
   localparam int unsigned DVD_W    = ACC_W;
   localparam int unsigned DVS_W    = BIN_W + 1;
   localparam int unsigned DIV_CNT_W = $clog2(DVD_W);
   localparam int unsigned VAR9_W   = VAR_W + 4;

   // highest bin index that can be counted
   localparam logic [BIN_W-1:0] BIN_LAST =
      BIN_W'((FRAME_BINS > (2 ** BIN_W)) ? (2 ** BIN_W) - 1 : FRAME_BINS - 1);

   // threshold factor, three sigma squared
   localparam int unsigned SIGMA_SQ = 9;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_BIN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_BIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOL_THRESH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRACTORY = 2'd3;

   localparam logic [BIN_W-1:0] RST_LOW_BIN    = 9'd1;
   localparam logic [BIN_W-1:0] RST_HIGH_BIN   = 9'd3;
   localparam logic [VOL_W-1:0] RST_VOL_THRESH = 16'd655;
   localparam logic [15:0]      RST_REFRACTORY = 16'd200;

   typedef struct packed {
      logic [BIN_W-1:0]  bin_index;
      logic [AMP_W-1:0]  amplitude;
      logic              frame_end;
      logic [VOL_W-1:0]  volume_level;
      logic [TIME_W-1:0] time_ms;
   } req_type;

   typedef struct packed {
      logic             beat;
      logic [AMP_W-1:0] bass_level;
      logic [AMP_W-1:0] bass_mean;
      logic [VAR_W-1:0] bass_variance;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/bass_beat_detector.sv =====
// ----------------------------------------------------------------------------
// bass_beat_detector
// energy / variance beat detection on a stream of spectrum bins
// ----------------------------------------------------------------------------
// usage
//   req channel: one spectrum bin per request (req_valid / req_stall). bins in
//   the bass range are summed; the request with frame_end closes the frame.
//   rsp channel: one result per frame (rsp_valid / rsp_stall) with beat flag,
//   bass level, history mean and history variance.
//   csr channel: register writes (csr_valid / csr_ready), ready is always high;
//   write only while no frame is in flight.
// throughput and stalls
//   a bin without frame_end is taken every cycle while req_stall is low and
//   gives no result. a frame_end request raises req_stall for one pass of
//   the bit-serial divider for the level, then two walks of the history
//   cell chain (sum, squared deviation), one entry per cycle. mean and
//   variance divide by the depth, a power of two, so they are plain shifts.
//   the result becomes valid in the same cycle that the stall ends.
// reset
//   synchronous: configuration registers go to their defaults, history cells to zero,
//   accumulator and last beat time to zero. no clearing pass.
// stalling
//   the result sits in an output register; bins keep being accepted while it
//   waits. a following frame_end waits at the end of its walk until the output
//   register is free.
// ----------------------------------------------------------------------------
module bass_beat_detector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bbd_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bbd_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bbd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bbd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bbd_pkg::*;

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;  // taking bins
   localparam logic [3:0] S_LEVEL  = 4'd1;  // divider: accumulator / span
   localparam logic [3:0] S_INSERT = 4'd2;  // push level into the chain
   localparam logic [3:0] S_SUM    = 4'd3;  // walk chain, sum entries
   localparam logic [3:0] S_VAR    = 4'd5;  // walk chain, squared deviation
   localparam logic [3:0] S_DRAIN  = 4'd6;  // let the square pipe empty
   localparam logic [3:0] S_DEV    = 4'd8;  // load level - mean into squarer
   localparam logic [3:0] S_SQ     = 4'd9;  // square it
   localparam logic [3:0] S_DONE   = 4'd10; // decide, write output register

   // configuration registers
   logic [BIN_W-1:0] low_bin_ff, low_bin_in;
   logic [BIN_W-1:0] high_bin_ff, high_bin_in;
   logic [VOL_W-1:0] vol_thr_ff, vol_thr_in;
   logic [15:0]      refr_ff, refr_in;

   // frame state
   logic [3:0]        state_ff, state_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [TIME_W-1:0] last_beat_ff, last_beat_in;
   logic [HIST_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]   sq_acc_ff, sq_acc_in;
   logic [AMP_W-1:0]  level_ff, level_in;
   logic [AMP_W-1:0]  mean_ff, mean_in;
   logic [VAR_W-1:0]  var_ff, var_in;
   logic              empty_ff, empty_in;
   logic [VOL_W-1:0]  vol_ff, vol_in;
   logic [TIME_W-1:0] time_ff, time_in;

   // squarer pipe, shared by the variance walk and the beat test
   logic [AMP_W-1:0]   d_ff, d_in;
   logic               d_vld_ff, d_vld_in;
   logic [2*AMP_W-1:0] p_ff, p_in;
   logic               p_vld_ff;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // history chain
   logic [AMP_W-1:0] hist [HISTORY_DEPTH];
   logic [AMP_W-1:0] tail;
   logic [AMP_W-1:0] head;
   logic             shift;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic              req_accept;
   logic              counted;
   logic [ACC_W-1:0]  acc_sum;
   logic [BIN_W-1:0]  hi_bin;
   logic              empty;
   logic [DVS_W-1:0]  span;
   logic [AMP_W-1:0]  abs_dev;
   logic              above;
   logic [VAR9_W-1:0] var9;
   logic [TIME_W-1:0] elapsed;
   logic              beat;
   logic              out_free;
   logic              rsp_write;
   logic              last_walk;

   // ---------------------------------------------------------------- handshakes
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------- bin range
   // clip the high bin at the last bin of the frame
   assign hi_bin  = (high_bin_ff > BIN_LAST) ? BIN_LAST : high_bin_ff;
   assign empty   = low_bin_ff > hi_bin;
   assign span    = {1'b0, hi_bin} - {1'b0, low_bin_ff} + 1'b1;
   assign counted = (req_data.bin_index <= BIN_LAST) &&
                    (req_data.bin_index >= low_bin_ff) &&
                    (req_data.bin_index <= high_bin_ff);
   // bin of the current request counts before the frame closes
   assign acc_sum = acc_ff + (counted ? {{(ACC_W-AMP_W){1'b0}}, req_data.amplitude}
                                      : {ACC_W{1'b0}});

   // ---------------------------------------------------------------- history chain
   assign head  = hist[0];
   assign tail  = (state_ff == S_INSERT) ? level_ff : head;
   assign shift = (state_ff == S_INSERT) || (state_ff == S_SUM) || (state_ff == S_VAR);

   for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
      if (g == HISTORY_DEPTH - 1) begin : g_tail
         bbd_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (shift),
            .din   (tail),
            .dout  (hist[g])
         );
      end else begin : g_body
         bbd_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (shift),
            .din   (hist[g+1]),
            .dout  (hist[g])
         );
      end
   end

   // ---------------------------------------------------------------- level divider
   bbd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign last_walk = (cnt_ff == HIST_W'(HISTORY_DEPTH - 1));

   // ---------------------------------------------------------------- squarer
   assign abs_dev = (head >= mean_ff) ? head - mean_ff : mean_ff - head;
   assign above   = level_ff > mean_ff;
   assign p_in    = {{AMP_W{1'b0}}, d_ff} * {{AMP_W{1'b0}}, d_ff};

   // ---------------------------------------------------------------- beat test
   assign var9     = {4'b0000, var_ff} * VAR9_W'(SIGMA_SQ);
   assign elapsed  = time_ff - last_beat_ff;
   assign beat     = above &&
                     ({{(VAR9_W-2*AMP_W){1'b0}}, p_ff} > var9) &&
                     (vol_ff > vol_thr_ff) &&
                     (elapsed > {{(TIME_W-16){1'b0}}, refr_ff});
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_write = (state_ff == S_DONE) && out_free;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      sq_acc_in    = sq_acc_ff;
      level_in     = level_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      empty_in     = empty_ff;
      vol_in       = vol_ff;
      time_in      = time_ff;
      d_in         = d_ff;
      d_vld_in     = 1'b0;
      last_beat_in = last_beat_ff;

      div_req.start    = 1'b0;
      div_req.dividend = acc_sum;
      div_req.divisor  = span;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_data.frame_end) begin
                  acc_in        = '0;
                  empty_in      = empty;
                  vol_in        = req_data.volume_level;
                  time_in       = req_data.time_ms;
                  div_req.start = 1'b1;
                  state_in      = S_LEVEL;
               end else begin
                  acc_in = acc_sum;
               end
            end
         end
         S_LEVEL: begin
            if (div_rsp.done) begin
               // saturate the level at full scale
               if (empty_ff) begin
                  level_in = '0;
               end else if (|div_rsp.quotient[DVD_W-1:AMP_W]) begin
                  level_in = '1;
               end else begin
                  level_in = div_rsp.quotient[AMP_W-1:0];
               end
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            cnt_in   = '0;
            sum_in   = '0;
            state_in = S_SUM;
         end
         S_SUM: begin
            sum_in = sum_ff + {{(SUM_W-AMP_W){1'b0}}, head};
            cnt_in = cnt_ff + 1'b1;
            if (last_walk) begin
               // depth is a power of two, the divide is a shift
               mean_in   = AMP_W'(sum_in / SUM_W'(HISTORY_DEPTH));
               cnt_in    = '0;
               sq_acc_in = '0;
               state_in  = S_VAR;
            end
         end
         S_VAR: begin
            d_in     = abs_dev;
            d_vld_in = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (p_vld_ff) begin
               sq_acc_in = sq_acc_ff + {{(SQ_W-2*AMP_W){1'b0}}, p_ff};
            end
            if (last_walk) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (p_vld_ff) begin
               sq_acc_in = sq_acc_ff + {{(SQ_W-2*AMP_W){1'b0}}, p_ff};
            end
            if (!d_vld_ff && !p_vld_ff) begin
               var_in   = VAR_W'(sq_acc_ff / SQ_W'(HISTORY_DEPTH));
               state_in = S_DEV;
            end
         end
         S_DEV: begin
            d_in     = above ? level_ff - mean_ff : '0;
            state_in = S_SQ;
         end
         S_SQ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               if (beat) begin
                  last_beat_in = time_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- output register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_write) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.beat          = beat;
         rsp_data_in.bass_level    = level_ff;
         rsp_data_in.bass_mean     = mean_ff;
         rsp_data_in.bass_variance = var_ff;
      end
   end

   // ---------------------------------------------------------------- csr writes
   always_comb begin
      low_bin_in  = low_bin_ff;
      high_bin_in = high_bin_ff;
      vol_thr_in  = vol_thr_ff;
      refr_in     = refr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOW_BIN:    low_bin_in  = csr_data[BIN_W-1:0];
            CSR_HIGH_BIN:   high_bin_in = csr_data[BIN_W-1:0];
            CSR_VOL_THRESH: vol_thr_in  = csr_data[VOL_W-1:0];
            CSR_REFRACTORY: refr_in     = csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         last_beat_ff <= '0;
         d_vld_ff     <= 1'b0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         low_bin_ff   <= RST_LOW_BIN;
         high_bin_ff  <= RST_HIGH_BIN;
         vol_thr_ff   <= RST_VOL_THRESH;
         refr_ff      <= RST_REFRACTORY;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         last_beat_ff <= last_beat_in;
         d_vld_ff     <= d_vld_in;
         p_vld_ff     <= d_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
         low_bin_ff   <= low_bin_in;
         high_bin_ff  <= high_bin_in;
         vol_thr_ff   <= vol_thr_in;
         refr_ff      <= refr_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      sum_ff      <= sum_in;
      sq_acc_ff   <= sq_acc_in;
      level_ff    <= level_in;
      mean_ff     <= mean_in;
      var_ff      <= var_in;
      empty_ff    <= empty_in;
      vol_ff      <= vol_in;
      time_ff     <= time_in;
      d_ff        <= d_in;
      p_ff        <= p_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/bbd_cell.sv =====
// ----------------------------------------------------------------------------
// bbd_cell
// one history entry, takes its neighbor's value on each shift
// ----------------------------------------------------------------------------
module bbd_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift,
   input  logic [bbd_pkg::AMP_W-1:0] din,
   output logic [bbd_pkg::AMP_W-1:0] dout
);
   import bbd_pkg::*;

   logic [AMP_W-1:0] val_ff;
   logic [AMP_W-1:0] val_in;

   assign val_in = shift ? din : val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else begin
         val_ff <= val_in;
      end
   end

   assign dout = val_ff;

endmodule

// ===== rtl/core/bbd_divider.sv =====
// ----------------------------------------------------------------------------
// bbd_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bbd_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  bbd_pkg::div_req_type div_req,
   output bbd_pkg::div_rsp_type div_rsp
);
   import bbd_pkg::*;

   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DVS_W:0]       rem_sh;
   logic [DVS_W:0]       rem_diff;
   logic                 ge;

   // shift in next dividend bit, try subtract
   assign rem_sh   = {rem_ff, quo_ff[DVD_W-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};
   assign ge       = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/bbd_checker.sv =====
// ----------------------------------------------------------------------------
// bbd_checker
// port level assertions for the bass beat detector, bound to the top level
// ----------------------------------------------------------------------------
`include "bass_beat_detector_assert.svh"

module bbd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input bbd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bbd_pkg::rsp_type rsp_data
);

   // reset leaves the block empty and open for bins
   `BBD_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid && !req_stall, "not idle after reset")

   // a held result keeps its payload
   `BBD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

   // closing a frame raises the stall
   `BBD_ASSERT(a_frame_stalls, req_valid && !req_stall && req_data.frame_end |=> req_stall, "frame end did not stall")

   // plain bins stream without a stall
   `BBD_ASSERT(a_bin_streams, req_valid && !req_stall && !req_data.frame_end |=> !req_stall, "bin caused a stall")

   // a beat needs a level above the mean
   `BBD_ASSERT(a_beat_above_mean, rsp_valid && rsp_data.beat |-> rsp_data.bass_level > rsp_data.bass_mean, "beat without level above mean")

endmodule

bind bass_beat_detector bbd_checker u_bbd_checker (.*);
